[hdl/prc_pkg.sv]
// ============================================================================
// Position result cache package
// Shared types and constants for the position result cache.
// ============================================================================
package prc_pkg;

    localparam int SLOTS     = 6;
    localparam int TAG_W     = 128;
    localparam int WIN_W     = 2;
    localparam int SLOT_IDX_W = 3;

    localparam logic [WIN_W-1:0] WIN_BLUE   = 2'd0;
    localparam logic [WIN_W-1:0] WIN_ORANGE = 2'd1;
    localparam logic [WIN_W-1:0] WIN_NONE   = 2'd2;
    localparam logic [WIN_W-1:0] WIN_BAD    = 2'd3;

    localparam logic FUNC_STORE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [1:0] STONES_ZERO  = 2'd0;
    localparam logic [1:0] STONES_THREE = 2'd3;

    typedef logic [SLOTS-1:0][WIN_W-1:0] slot_vec_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        slot_vec_t        slots;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             func;
        logic [TAG_W-1:0] tag;
        logic             mover;
        logic [1:0]       stones;
        logic [WIN_W-1:0] winner;
    } req_t;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

endpackage

[hdl/prc_ram.sv]
// ============================================================================
// Generic RAM
// One write port and one read port with a registered read.
// ============================================================================
module prc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/prc_update.sv]
// ============================================================================
// Position result cache entry update
// Compares the tag, forms the new entry for a store and the lookup answer.
// ============================================================================
module prc_update (
    input  prc_pkg::req_t                  req,
    input  prc_pkg::entry_t                rd_entry,
    output prc_pkg::entry_t                wr_entry,
    output logic [prc_pkg::WIN_W-1:0]      lookup_winner
);

    logic                              match;
    logic [1:0]                        stones_eff;
    logic [prc_pkg::WIN_W-1:0]         win_eff;
    logic [prc_pkg::SLOT_IDX_W-1:0]    slot_lo;
    logic [prc_pkg::SLOT_IDX_W-1:0]    slot_hi;
    prc_pkg::slot_vec_t                base_slots;

    always_comb
    begin
        match      = (rd_entry.tag == req.tag);
        stones_eff = (req.stones == prc_pkg::STONES_ZERO) ? prc_pkg::STONES_THREE : req.stones;
        win_eff    = (req.winner == prc_pkg::WIN_BAD) ? prc_pkg::WIN_NONE : req.winner;
        slot_lo    = req.mover ? 3'd3 : 3'd0;
        slot_hi    = slot_lo + 3'd3 - {1'b0, stones_eff};

        base_slots = match ? rd_entry.slots : {prc_pkg::SLOTS{prc_pkg::WIN_NONE}};

        wr_entry.tag = req.tag;
        for (int k = 0; k < prc_pkg::SLOTS; k++)
        begin
            if ((3'(k) >= slot_lo) && (3'(k) <= slot_hi))
            begin
                wr_entry.slots[k] = win_eff;
            end
            else
            begin
                wr_entry.slots[k] = base_slots[k];
            end
        end

        lookup_winner = match ? rd_entry.slots[slot_hi] : prc_pkg::WIN_NONE;
    end

endmodule

[hdl/position_result_cache.sv]
// ============================================================================
// Position result cache
// Direct-mapped cache of search results, keyed by position hash and tag.
// ============================================================================
// A request is transferred at a rising edge where start is high and busy is
// low. The fields func, hash_key, tag_low, tag_high, mover, stones and
// winner_in are sampled at that edge. The low bits of hash_key select one of
// ENTRIES entries, which must be a power of two.
// A store gives no result. A lookup gives one result: done is high for
// exactly one cycle with stored_winner valid, from registers loaded in the
// update state. The receiver cannot stall, so the result must be taken.
// Each request has two steps: the registered memory read at the transfer,
// then the compare and write back in the update state, in which busy is high.
// No new request can be transferred while busy, so the read of a request
// always sees the write back of the one before it.
// After reset the block sweeps the memory, one entry per cycle, clearing
// every tag to zero and every slot to none, and busy stays high until the
// sweep ends.
// ============================================================================
module position_result_cache #(
    parameter int ENTRIES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [63:0] hash_key,
    input  logic [63:0] tag_low,
    input  logic [63:0] tag_high,
    input  logic        mover,
    input  logic [1:0]  stones,
    input  logic [1:0]  winner_in,
    output logic        done,
    output logic [1:0]  stored_winner
);

    localparam int AW = $clog2(ENTRIES);

    prc_pkg::state_t            state_reg;
    prc_pkg::state_t            state_next;
    logic [AW-1:0]              clr_idx_reg;
    logic [AW-1:0]              clr_idx_next;
    prc_pkg::req_t              req_reg;
    logic [AW-1:0]              idx_reg;
    logic                       done_reg;
    logic                       done_next;
    logic [prc_pkg::WIN_W-1:0]  winner_reg;

    logic                       accept;
    logic                       ram_wr_en;
    logic [AW-1:0]              ram_wr_addr;
    prc_pkg::entry_t            ram_wr_data;
    prc_pkg::entry_t            ram_rd_data;
    prc_pkg::entry_t            upd_entry;
    logic [prc_pkg::WIN_W-1:0]  upd_winner;

    assign accept = start && (state_reg == prc_pkg::ST_IDLE);
    assign busy   = (state_reg != prc_pkg::ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        done_next    = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = idx_reg;
        ram_wr_data  = upd_entry;
        unique case (state_reg)
            prc_pkg::ST_CLEAR:
            begin
                ram_wr_en         = 1'b1;
                ram_wr_addr       = clr_idx_reg;
                ram_wr_data.tag   = '0;
                ram_wr_data.slots = {prc_pkg::SLOTS{prc_pkg::WIN_NONE}};
                clr_idx_next      = clr_idx_reg + AW'(1);
                if (clr_idx_reg == AW'(ENTRIES - 1))
                begin
                    state_next = prc_pkg::ST_IDLE;
                end
            end
            prc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = prc_pkg::ST_UPDATE;
                end
            end
            prc_pkg::ST_UPDATE:
            begin
                ram_wr_en  = (req_reg.func == prc_pkg::FUNC_STORE);
                done_next  = (req_reg.func == prc_pkg::FUNC_LOOKUP);
                state_next = prc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = prc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= prc_pkg::ST_CLEAR;
            clr_idx_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.func   <= func;
            req_reg.tag    <= {tag_high, tag_low};
            req_reg.mover  <= mover;
            req_reg.stones <= stones;
            req_reg.winner <= winner_in;
            idx_reg        <= hash_key[AW-1:0];
        end
        if (done_next)
        begin
            winner_reg <= upd_winner;
        end
    end

    prc_ram #(
        .WIDTH (prc_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (hash_key[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    prc_update u_update (
        .req           (req_reg),
        .rd_entry      (ram_rd_data),
        .wr_entry      (upd_entry),
        .lookup_winner (upd_winner)
    );

    assign done          = done_reg;
    assign stored_winner = winner_reg;

endmodule

[hdl/prc_checker.sv]
// ============================================================================
// Position result cache checker
// Port-level checks of request and result timing, bound to the top level.
// ============================================================================
module prc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       func,
    input logic       done,
    input logic [1:0] stored_winner
);

    a_lookup_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy && func == prc_pkg::FUNC_LOOKUP) |-> ##2 done
    ) else $error("A lookup did not give a result two cycles after its transfer.");

    a_store_gives_none: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy && func == prc_pkg::FUNC_STORE) |-> ##2 !done
    ) else $error("A store gave a result.");

    a_result_has_lookup: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && func == prc_pkg::FUNC_LOOKUP, 2)
    ) else $error("A result appeared without a lookup two cycles earlier.");

    a_busy_after_transfer: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy
    ) else $error("The block was not busy after a request transfer.");

    a_result_code_legal: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> (stored_winner != prc_pkg::WIN_BAD)
    ) else $error("A result carried an undefined winner code.");

endmodule

bind position_result_cache prc_checker u_prc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .done          (done),
    .stored_winner (stored_winner)
);

[sim/position_result_cache_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// Position result cache testbench
// Drives stores and lookups through the start/busy handshake, keeps its own
// copy of the cache contents to predict lookups, and compares each done
// strobe against the oldest expected winner. A short directed table comes
// first, followed by random traffic aimed at a few hot entries and tags so
// that hits, overwrites and fall-through writes occur often.
// ============================================================================
module position_result_cache_tb;

    localparam int ENTRIES  = 4096;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int DIRECTED = 24;
    localparam int PHASES   = 4;
    localparam int PER_PHASE = 150;
    localparam int MAX_GAP  = 40;
    localparam int LIMIT    = 200000;

    localparam logic [prc_pkg::TAG_W-1:0] TAG_A =
        128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210;
    localparam logic [prc_pkg::TAG_W-1:0] TAG_B =
        128'h5a5a_0f0f_c3c3_9696_a5a5_f0f0_3c3c_6969;
    localparam logic [prc_pkg::TAG_W-1:0] TAG_ONES = '1;
    localparam logic [63:0] KEY_ONES = '1;

    typedef struct {
        logic                      func;
        logic [63:0]               key;
        logic [prc_pkg::TAG_W-1:0] tag;
        logic                      mover;
        logic [1:0]                stones;
        logic [1:0]                winner;
        bit                        typed;
        logic [1:0]                want;
    } cache_req_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        func;
    logic [63:0] hash_key;
    logic [63:0] tag_low;
    logic [63:0] tag_high;
    logic        mover;
    logic [1:0]  stones;
    logic [1:0]  winner_in;
    logic        done;
    logic [1:0]  stored_winner;

    logic [prc_pkg::TAG_W-1:0] model_tag [ENTRIES];
    prc_pkg::slot_vec_t        model_slots [ENTRIES];
    logic [1:0]                pending_winners [$];
    int                        error_count = 0;
    int                        cycle_count = 0;

    position_result_cache #(
        .ENTRIES(ENTRIES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .hash_key(hash_key),
        .tag_low(tag_low),
        .tag_high(tag_high),
        .mover(mover),
        .stones(stones),
        .winner_in(winner_in),
        .done(done),
        .stored_winner(stored_winner)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic predict_winner(input cache_req_t rq, output bit has, output logic [1:0] res);
        int         idx;
        int         base;
        int         st;
        int         s;
        bit         hit;
        logic [1:0] w;
        idx  = int'(rq.key[IDX_W-1:0]);
        st   = (rq.stones == prc_pkg::STONES_ZERO) ? 3 : int'(rq.stones);
        base = 3 * int'(rq.mover);
        hit  = (model_tag[idx] == rq.tag);
        res  = prc_pkg::WIN_NONE;
        has  = 1'b0;
        if (rq.func == prc_pkg::FUNC_LOOKUP)
        begin
            has = 1'b1;
            if (hit)
                res = model_slots[idx][base + 3 - st];
        end
        else
        begin
            w = (rq.winner == prc_pkg::WIN_BAD) ? prc_pkg::WIN_NONE : rq.winner;
            if (!hit)
            begin
                model_tag[idx]   = rq.tag;
                model_slots[idx] = {prc_pkg::SLOTS{prc_pkg::WIN_NONE}};
            end
            for (s = st; s <= 3; s++)
                model_slots[idx][base + 3 - s] = w;
        end
    endtask

    task automatic send_request(input cache_req_t rq, input int gap);
        bit         has;
        logic [1:0] res;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start     <= 1'b1;
        func      <= rq.func;
        hash_key  <= rq.key;
        tag_low   <= rq.tag[63:0];
        tag_high  <= rq.tag[127:64];
        mover     <= rq.mover;
        stones    <= rq.stones;
        winner_in <= rq.winner;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_winner(rq, has, res);
        if (has)
            pending_winners.push_back(rq.typed ? rq.want : res);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_winners.size() == 0)
            begin
                $error("stored_winner: expected nothing, actual %0d", stored_winner);
                error_count++;
            end
            else
            begin
                if (stored_winner !== pending_winners[0])
                begin
                    $error("stored_winner: expected %0d, actual %0d",
                           pending_winners[0], stored_winner);
                    error_count++;
                end
                void'(pending_winners.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("position_result_cache_tb: errors");
            $finish;
        end
    end

    initial
    begin
        cache_req_t                directed_rows [DIRECTED];
        cache_req_t                rq;
        logic [prc_pkg::TAG_W-1:0] tag_pool [4];
        int                        hot_index [6];
        int                        idle_pct [PHASES];
        int                        e;
        int                        p;
        int                        n;
        int                        gap;

        start     <= 1'b0;
        func      <= prc_pkg::FUNC_STORE;
        hash_key  <= '0;
        tag_low   <= '0;
        tag_high  <= '0;
        mover     <= 1'b0;
        stones    <= prc_pkg::STONES_THREE;
        winner_in <= prc_pkg::WIN_NONE;
        rst_n     <= 1'b0;

        for (e = 0; e < ENTRIES; e++)
        begin
            model_tag[e]   = '0;
            model_slots[e] = {prc_pkg::SLOTS{prc_pkg::WIN_NONE}};
        end

        directed_rows = '{
            '{prc_pkg::FUNC_LOOKUP, 64'd0, 128'd0, 1'b0, 2'd1, prc_pkg::WIN_BLUE,
              1'b1, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_LOOKUP, KEY_ONES, TAG_ONES, 1'b1, 2'd3, prc_pkg::WIN_ORANGE,
              1'b1, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_STORE, 64'd5, TAG_A, 1'b0, 2'd1, prc_pkg::WIN_BLUE,
              1'b0, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_LOOKUP, 64'd5, TAG_A, 1'b0, 2'd1, prc_pkg::WIN_NONE,
              1'b1, prc_pkg::WIN_BLUE},
            '{prc_pkg::FUNC_LOOKUP, 64'd5, TAG_A, 1'b0, 2'd3, prc_pkg::WIN_BAD,
              1'b1, prc_pkg::WIN_BLUE},
            '{prc_pkg::FUNC_LOOKUP, 64'd5, TAG_A, 1'b1, 2'd1, prc_pkg::WIN_BLUE,
              1'b1, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_STORE, 64'd5, TAG_A, 1'b0, 2'd2, prc_pkg::WIN_ORANGE,
              1'b0, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_LOOKUP, 64'd5, TAG_A, 1'b0, 2'd1, prc_pkg::WIN_NONE,
              1'b0, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_LOOKUP, 64'd5, TAG_A, 1'b0, 2'd2, prc_pkg::WIN_NONE,
              1'b0, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_LOOKUP, 64'd5, TAG_A, 1'b0, 2'd0, prc_pkg::WIN_NONE,
              1'b0, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_STORE, 64'd5, TAG_B, 1'b1, 2'd3, prc_pkg::WIN_ORANGE,
              1'b0, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_LOOKUP, 64'd5, TAG_A, 1'b0, 2'd1, prc_pkg::WIN_NONE,
              1'b1, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_LOOKUP, 64'd5, TAG_B, 1'b1, 2'd0, prc_pkg::WIN_NONE,
              1'b0, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_LOOKUP, 64'd5, TAG_B, 1'b0, 2'd3, prc_pkg::WIN_NONE,
              1'b0, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_STORE, 64'd5, TAG_B, 1'b1, 2'd1, prc_pkg::WIN_BAD,
              1'b0, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_LOOKUP, 64'd5, TAG_B, 1'b1, 2'd1, prc_pkg::WIN_NONE,
              1'b1, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_STORE, 64'hffff_ffff_ffff_f005, TAG_B, 1'b1, 2'd0,
              prc_pkg::WIN_BLUE, 1'b0, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_LOOKUP, 64'd5, TAG_B, 1'b1, 2'd3, prc_pkg::WIN_NONE,
              1'b0, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_LOOKUP, 64'd5, TAG_B, 1'b1, 2'd2, prc_pkg::WIN_NONE,
              1'b0, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_STORE, 64'd0, 128'd0, 1'b1, 2'd2, prc_pkg::WIN_BLUE,
              1'b0, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_LOOKUP, 64'd0, 128'd0, 1'b1, 2'd3, prc_pkg::WIN_NONE,
              1'b0, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_STORE, KEY_ONES, TAG_ONES, 1'b0, 2'd3, prc_pkg::WIN_ORANGE,
              1'b0, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_LOOKUP, KEY_ONES, TAG_ONES, 1'b0, 2'd3, prc_pkg::WIN_NONE,
              1'b0, prc_pkg::WIN_NONE},
            '{prc_pkg::FUNC_LOOKUP, KEY_ONES, TAG_A, 1'b0, 2'd3, prc_pkg::WIN_NONE,
              1'b0, prc_pkg::WIN_NONE}
        };

        tag_pool[0] = '0;
        tag_pool[1] = TAG_A;
        tag_pool[2] = {$urandom, $urandom, $urandom, $urandom};
        tag_pool[3] = {$urandom, $urandom, $urandom, $urandom};
        hot_index   = '{0, 1, 5, 7, 100, ENTRIES - 1};
        idle_pct    = '{0, 85, 11, 0};

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < DIRECTED; n++)
            send_request(directed_rows[n], 0);

        for (p = 0; p < PHASES; p++)
        begin
            for (n = 0; n < PER_PHASE; n++)
            begin
                rq.func   = 1'($urandom_range(1));
                rq.key    = {$urandom, $urandom};
                if ($urandom_range(9) < 8)
                    rq.key[IDX_W-1:0] = IDX_W'(hot_index[$urandom_range(5)]);
                if ($urandom_range(3) != 0)
                    rq.tag = tag_pool[$urandom_range(3)];
                else
                    rq.tag = {$urandom, $urandom, $urandom, $urandom};
                rq.mover  = 1'($urandom_range(1));
                rq.stones = 2'($urandom_range(3));
                rq.winner = 2'($urandom_range(3));
                rq.typed  = 1'b0;
                rq.want   = prc_pkg::WIN_NONE;
                gap = 0;
                while (idle_pct[p] > 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct[p])
                    gap++;
                send_request(rq, gap);
            end
        end

        @(negedge clk);
        start <= 1'b0;

        while (pending_winners.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (error_count == 0)
            $display("position_result_cache_tb: clean");
        else
            $display("position_result_cache_tb: errors");
        $finish;
    end

endmodule
